// ===== rtl/hcsg_pkg.sv =====
// Shared types, constants and the per-level Hilbert mapping function for the
// Hilbert curve step generator. No dependencies.
`timescale 1ns / 1ps

package hcsg_pkg;

   localparam int MAX_ORDER        = 8;
   localparam int ORDER_W          = 4;
   localparam int COORD_W          = 8;
   localparam int INDEX_W          = 2 * MAX_ORDER;
   localparam int LEVELS_PER_STAGE = 2;
   localparam int NUM_LEVEL_STAGES = MAX_ORDER / LEVELS_PER_STAGE;
   localparam int LEVEL_W          = $clog2(MAX_ORDER);

   localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_W'(3);
   localparam logic [ORDER_W-1:0] ORDER_MIN   = ORDER_W'(1);
   localparam logic [ORDER_W-1:0] ORDER_MAX   = ORDER_W'(MAX_ORDER);

   typedef struct packed {
      logic [INDEX_W-1:0] t;       // remaining index digits, low pair first
      logic [COORD_W-1:0] sx;
      logic [COORD_W-1:0] sy;
      logic [ORDER_W-1:0] order;
      logic               last;
      logic               origin;  // segment starts at the origin
   } hcsg_stage_type;

   typedef struct packed {
      logic [COORD_W-1:0] sx;
      logic [COORD_W-1:0] sy;
   } hcsg_xy_type;

   function automatic logic [ORDER_W-1:0] eff_order(input logic [ORDER_W-1:0] raw);
      logic [ORDER_W-1:0] n;
      begin
         n = raw;
         if (n < ORDER_MIN) n = ORDER_MIN;
         if (n > ORDER_MAX) n = ORDER_MAX;
         return n;
      end
   endfunction

   // Number of segments of a curve of the given order: 4^order - 1.
   function automatic logic [INDEX_W-1:0] seg_count(input logic [ORDER_W-1:0] order);
      logic [INDEX_W:0] full;
      begin
         full = (INDEX_W+1)'(1) << {order, 1'b0};
         return INDEX_W'(full - (INDEX_W+1)'(1));
      end
   endfunction

   // One level of the index-to-point mapping; levels at or above the order
   // leave the point untouched.
   function automatic hcsg_xy_type hil_level(
      input hcsg_xy_type        p,
      input logic [1:0]         digit,
      input logic [LEVEL_W-1:0] lvl,
      input logic [ORDER_W-1:0] order
   );
      hcsg_xy_type        r;
      logic               rx;
      logic               ry;
      logic [COORD_W-1:0] bitv;
      logic [COORD_W-1:0] mask;
      logic [COORD_W-1:0] tmp;
      begin
         r    = p;
         rx   = digit[1];
         ry   = digit[0] ^ digit[1];
         bitv = COORD_W'(1) << lvl;
         mask = bitv - COORD_W'(1);
         if (ORDER_W'(lvl) < order) begin
            if (!ry) begin
               if (rx) begin
                  r.sx = r.sx ^ mask;
                  r.sy = r.sy ^ mask;
               end
               tmp  = r.sx;
               r.sx = r.sy;
               r.sy = tmp;
            end
            if (rx) r.sx = r.sx | bitv;
            if (ry) r.sy = r.sy | bitv;
         end
         return r;
      end
   endfunction

endpackage

// ===== rtl/hcsg_walk.sv =====
// Walk state of the Hilbert step generator: order register, segment index and
// the first pipeline register. Depends on hcsg_pkg.
`timescale 1ns / 1ps

module hcsg_walk (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          req_valid,
   input  logic                          req_restart,
   input  logic                          csr_valid,
   input  logic [hcsg_pkg::ORDER_W-1:0]  csr_curve_order,
   output logic                          stage_valid,
   output hcsg_pkg::hcsg_stage_type      stage_data
);
   import hcsg_pkg::*;

   logic [ORDER_W-1:0] order_ff, order_in;
   logic [INDEX_W-1:0] index_ff, index_in;
   logic               valid_ff, valid_in;
   hcsg_stage_type     data_ff, data_in;

   logic [ORDER_W-1:0] order;
   logic [INDEX_W-1:0] segs;
   logic [INDEX_W-1:0] index_eff;
   logic [INDEX_W-1:0] next_index;
   logic               last;
   logic               accept;

   always_comb begin
      order      = eff_order(order_ff);
      segs       = seg_count(order);
      index_eff  = (req_restart || index_ff >= segs) ? '0 : index_ff;
      last       = (index_eff == segs - INDEX_W'(1));
      next_index = index_eff + INDEX_W'(1);
      accept     = req_valid && advance;

      order_in = order_ff;
      index_in = index_ff;
      if (csr_valid) begin
         order_in = csr_curve_order;
         index_in = '0;
      end else if (accept) begin
         index_in = last ? '0 : next_index;
      end

      valid_in       = advance ? req_valid : valid_ff;
      data_in        = data_ff;
      if (advance) begin
         data_in.t      = next_index;
         data_in.sx     = '0;
         data_in.sy     = '0;
         data_in.order  = order;
         data_in.last   = last;
         data_in.origin = (index_eff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= ORDER_RESET;
         index_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         order_ff <= order_in;
         index_ff <= index_in;
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign stage_valid = valid_ff;
   assign stage_data  = data_ff;

endmodule

// ===== rtl/hcsg_level_stage.sv =====
// One pipeline stage of the Hilbert index-to-point mapping, two levels deep.
// Depends on hcsg_pkg.
`timescale 1ns / 1ps

module hcsg_level_stage (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic [hcsg_pkg::LEVEL_W-1:0]  level_base,
   input  logic                          in_valid,
   input  hcsg_pkg::hcsg_stage_type      in_data,
   output logic                          out_valid,
   output hcsg_pkg::hcsg_stage_type      out_data
);
   import hcsg_pkg::*;

   logic           valid_ff, valid_in;
   hcsg_stage_type data_ff, data_in;
   hcsg_xy_type    p0, p1, p2;

   always_comb begin
      p0.sx = in_data.sx;
      p0.sy = in_data.sy;
      p1 = hil_level(p0, in_data.t[1:0], level_base, in_data.order);
      p2 = hil_level(p1, in_data.t[3:2], level_base + LEVEL_W'(1), in_data.order);

      valid_in = advance ? in_valid : valid_ff;
      data_in  = data_ff;
      if (advance) begin
         data_in    = in_data;
         data_in.t  = in_data.t >> (2 * LEVELS_PER_STAGE);
         data_in.sx = p2.sx;
         data_in.sy = p2.sy;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/hcsg_out.sv =====
// Output register of the Hilbert step generator: exchanges the coordinates and
// supplies the segment start from the previous end point. Depends on hcsg_pkg.
`timescale 1ns / 1ps

module hcsg_out (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  hcsg_pkg::hcsg_stage_type      in_data,
   input  logic                          rsp_ready,
   output logic                          advance,
   output logic                          rsp_valid,
   output logic [hcsg_pkg::COORD_W-1:0]  rsp_from_x,
   output logic [hcsg_pkg::COORD_W-1:0]  rsp_from_y,
   output logic [hcsg_pkg::COORD_W-1:0]  rsp_to_x,
   output logic [hcsg_pkg::COORD_W-1:0]  rsp_to_y,
   output logic                          rsp_last_segment
);
   import hcsg_pkg::*;

   logic               valid_ff, valid_in;
   logic [COORD_W-1:0] from_x_ff, from_x_in;
   logic [COORD_W-1:0] from_y_ff, from_y_in;
   logic [COORD_W-1:0] to_x_ff, to_x_in;
   logic [COORD_W-1:0] to_y_ff, to_y_in;
   logic               last_ff, last_in;
   // End point of the most recent segment; items leave in order, so it is the
   // start of the next one unless that one begins at the origin.
   logic [COORD_W-1:0] prev_x_ff, prev_x_in;
   logic [COORD_W-1:0] prev_y_ff, prev_y_in;

   always_comb begin
      advance   = !valid_ff || rsp_ready;
      valid_in  = advance ? in_valid : valid_ff;
      from_x_in = from_x_ff;
      from_y_in = from_y_ff;
      to_x_in   = to_x_ff;
      to_y_in   = to_y_ff;
      last_in   = last_ff;
      prev_x_in = prev_x_ff;
      prev_y_in = prev_y_ff;
      if (advance && in_valid) begin
         from_x_in = in_data.origin ? '0 : prev_x_ff;
         from_y_in = in_data.origin ? '0 : prev_y_ff;
         to_x_in   = in_data.sy;
         to_y_in   = in_data.sx;
         last_in   = in_data.last;
         prev_x_in = in_data.sy;
         prev_y_in = in_data.sx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      from_x_ff <= from_x_in;
      from_y_ff <= from_y_in;
      to_x_ff   <= to_x_in;
      to_y_ff   <= to_y_in;
      last_ff   <= last_in;
      prev_x_ff <= prev_x_in;
      prev_y_ff <= prev_y_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_from_x       = from_x_ff;
   assign rsp_from_y       = from_y_ff;
   assign rsp_to_x         = to_x_ff;
   assign rsp_to_y         = to_y_ff;
   assign rsp_last_segment = last_ff;

endmodule

// ===== rtl/hilbert_curve_step_generator.sv =====
// Top level of the Hilbert curve step generator: walk state, four mapping
// stages and the output register. Depends on hcsg_pkg and all hcsg_ modules.
`timescale 1ns / 1ps

// Each transfer on the req channel asks for the next unit segment of a Hilbert
// curve on a 2^order by 2^order grid; req_restart set sends the walk back to
// the origin first. Each request yields exactly one transfer on the rsp
// channel with the segment's start and end points and a flag on the final
// segment, after which the walk wraps to the origin.
// The csr channel writes the curve order (0 acts as 1, above 8 acts as 8);
// a write also returns the walk to the origin. It is always ready and should
// be used only while no request is in flight.
// A request passes through one walk register, four mapping stages of two curve
// levels each, and the output register before its result is on the rsp port.
// Throughput: one segment per cycle; the whole pipeline advances together
// whenever the output register is empty or being drained.
// When the receiver stalls, the pipeline holds and req_ready drops; nothing
// is lost or repeated. Reset (synchronous) empties the pipeline, sets the
// order to 3 and puts the walk at the origin.

module hilbert_curve_step_generator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_restart,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [hcsg_pkg::COORD_W-1:0]  rsp_from_x,
   output logic [hcsg_pkg::COORD_W-1:0]  rsp_from_y,
   output logic [hcsg_pkg::COORD_W-1:0]  rsp_to_x,
   output logic [hcsg_pkg::COORD_W-1:0]  rsp_to_y,
   output logic                          rsp_last_segment,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [hcsg_pkg::ORDER_W-1:0]  csr_curve_order
);
   import hcsg_pkg::*;

   logic           advance;
   logic           stage_valid [NUM_LEVEL_STAGES+1];
   hcsg_stage_type stage_data  [NUM_LEVEL_STAGES+1];

   assign req_ready = advance;
   assign csr_ready = 1'b1;

   hcsg_walk u_walk (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .req_valid       (req_valid),
      .req_restart     (req_restart),
      .csr_valid       (csr_valid),
      .csr_curve_order (csr_curve_order),
      .stage_valid     (stage_valid[0]),
      .stage_data      (stage_data[0])
   );

   for (genvar g = 0; g < NUM_LEVEL_STAGES; g++) begin : g_level
      hcsg_level_stage u_level (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .level_base (LEVEL_W'(g * LEVELS_PER_STAGE)),
         .in_valid   (stage_valid[g]),
         .in_data    (stage_data[g]),
         .out_valid  (stage_valid[g+1]),
         .out_data   (stage_data[g+1])
      );
   end

   hcsg_out u_out (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (stage_valid[NUM_LEVEL_STAGES]),
      .in_data          (stage_data[NUM_LEVEL_STAGES]),
      .rsp_ready        (rsp_ready),
      .advance          (advance),
      .rsp_valid        (rsp_valid),
      .rsp_from_x       (rsp_from_x),
      .rsp_from_y       (rsp_from_y),
      .rsp_to_x         (rsp_to_x),
      .rsp_to_y         (rsp_to_y),
      .rsp_last_segment (rsp_last_segment)
   );

   // Every segment is one grid step long.
   a_unit_step : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_from_x == rsp_to_x &&
            (COORD_W'(rsp_from_y + COORD_W'(1)) == rsp_to_y ||
             COORD_W'(rsp_to_y + COORD_W'(1)) == rsp_from_y)) ||
         (rsp_from_y == rsp_to_y &&
            (COORD_W'(rsp_from_x + COORD_W'(1)) == rsp_to_x ||
             COORD_W'(rsp_to_x + COORD_W'(1)) == rsp_from_x)))
      else $error("segment is not a unit step");

   // The curve always ends on the y axis.
   a_last_on_axis : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_segment |-> rsp_to_x == '0)
      else $error("final segment does not end at x zero");

   // A stalled output must hold the whole pipeline, input included.
   a_stall_blocks_input : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while the output is stalled");

   // Reset empties the pipeline.
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present right after reset");

endmodule

// ===== dv/tb_hilbert_curve_step_generator.sv =====
// Self-checking testbench for hilbert_curve_step_generator: predicts each curve segment
// from its own walk state and compares every rsp transfer with the oldest prediction.
// Depends on hcsg_pkg and the RTL of the step generator.
`timescale 1ns / 1ps

module tb_hilbert_curve_step_generator;

   import hcsg_pkg::*;

   typedef struct packed {
      logic [COORD_W-1:0] from_x;
      logic [COORD_W-1:0] from_y;
      logic [COORD_W-1:0] to_x;
      logic [COORD_W-1:0] to_y;
      logic               last;
   } segment_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_restart = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [COORD_W-1:0]  rsp_from_x;
   logic [COORD_W-1:0]  rsp_from_y;
   logic [COORD_W-1:0]  rsp_to_x;
   logic [COORD_W-1:0]  rsp_to_y;
   logic                rsp_last_segment;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [ORDER_W-1:0]  csr_curve_order = '0;

   // Walk state of the predictor.
   logic [ORDER_W-1:0]  model_order = ORDER_RESET;
   logic [INDEX_W-1:0]  model_index = '0;
   logic [COORD_W-1:0]  model_x = '0;
   logic [COORD_W-1:0]  model_y = '0;

   bit                  walk_requests[$];
   segment_type         segments_due[$];
   // Requests put on the port by the driver and requests seen in transfer.
   int                  req_issued = 0;
   int                  req_taken = 0;
   int                  send_gap_pct = 0;
   int                  recv_stall_pct = 0;
   int                  mismatches = 0;

   // Random sections: order written, item count, restart percentage.
   int                  plan_order[12] = '{1, 2, 15, 4, 0, 8, 3, 9, 5, 2, 12, 1};
   int                  plan_len[12] = '{150, 150, 150, 300, 120, 150, 200, 150, 150, 150,
                                         130, 100};
   int                  plan_restart[12] = '{3, 3, 40, 2, 3, 2, 3, 30, 2, 3, 5, 3};

   hilbert_curve_step_generator u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_from_x       (rsp_from_x),
      .rsp_from_y       (rsp_from_y),
      .rsp_to_x         (rsp_to_x),
      .rsp_to_y         (rsp_to_y),
      .rsp_last_segment (rsp_last_segment),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_curve_order  (csr_curve_order)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Hilbert index to grid point, x and y exchanged against the textbook form.
   function automatic void grid_point(input int unsigned idx, input int unsigned order,
                                      output logic [COORD_W-1:0] gx,
                                      output logic [COORD_W-1:0] gy);
      int unsigned cx;
      int unsigned cy;
      int unsigned rest;
      int unsigned side;
      int unsigned qx;
      int unsigned qy;
      int unsigned swap;
      int unsigned lvl;
      cx = 0;
      cy = 0;
      rest = idx;
      for (lvl = 0; lvl < order; lvl++) begin
         side = 1 << lvl;
         qx = (rest >> 1) & 1;
         qy = (rest ^ qx) & 1;
         if (qy == 0) begin
            if (qx == 1) begin
               cx = side - 1 - cx;
               cy = side - 1 - cy;
            end
            swap = cx;
            cx = cy;
            cy = swap;
         end
         cx += side * qx;
         cy += side * qy;
         rest >>= 2;
      end
      gx = cy[COORD_W-1:0];
      gy = cx[COORD_W-1:0];
   endfunction

   function automatic segment_type next_segment(input bit restart);
      segment_type seg;
      int unsigned order;
      int unsigned seg_total;
      logic [COORD_W-1:0] nx;
      logic [COORD_W-1:0] ny;
      order = model_order;
      if (order < 1) order = 1;
      if (order > MAX_ORDER) order = MAX_ORDER;
      seg_total = (1 << (2 * order)) - 1;
      if (restart || model_index >= seg_total) begin
         model_index = '0;
         model_x = '0;
         model_y = '0;
      end
      grid_point(model_index + 1, order, nx, ny);
      seg.from_x = model_x;
      seg.from_y = model_y;
      seg.to_x = nx;
      seg.to_y = ny;
      seg.last = (model_index + 1 == seg_total);
      if (seg.last) begin
         model_index = '0;
         model_x = '0;
         model_y = '0;
      end else begin
         model_index = model_index + 1'b1;
         model_x = nx;
         model_y = ny;
      end
      return seg;
   endfunction

   task automatic check_field(input string what, input logic [COORD_W-1:0] want,
                              input logic [COORD_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
         mismatches++;
      end
   endtask

   // Monitor: order updates, predictions on req transfers, checks on rsp transfers.
   always @(posedge clock) begin
      segment_type want;
      if (reset) begin
         model_order = ORDER_RESET;
         model_index = '0;
         model_x = '0;
         model_y = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            model_order = csr_curve_order;
            model_index = '0;
            model_x = '0;
            model_y = '0;
         end
         if (req_valid && req_ready) begin
            segments_due.push_back(next_segment(req_restart));
            void'(walk_requests.pop_front());
            req_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            if (segments_due.size() == 0) begin
               $display("%0t: unexpected segment transfer from (%0d,%0d) to (%0d,%0d)",
                        $time, rsp_from_x, rsp_from_y, rsp_to_x, rsp_to_y);
               mismatches++;
            end else begin
               want = segments_due.pop_front();
               check_field("from_x", want.from_x, rsp_from_x);
               check_field("from_y", want.from_y, rsp_from_y);
               check_field("to_x", want.to_x, rsp_to_x);
               check_field("to_y", want.to_y, rsp_to_y);
               check_field("last_segment", COORD_W'(want.last), COORD_W'(rsp_last_segment));
            end
         end
      end
   end

   // Driver: a request stays up until its transfer, then the next one may follow a gap.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_taken == req_issued) begin
         if (walk_requests.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
            req_valid <= 1'b1;
            req_restart <= walk_requests[0];
            req_issued++;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic write_curve_order(input logic [ORDER_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_curve_order <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // A negative restart percentage takes the restart bits from the pattern instead.
   task automatic run_section(input bit write_order, input logic [ORDER_W-1:0] order,
                              input int count, input int restart_pct,
                              input logic [31:0] pattern);
      int i;
      if (write_order) write_curve_order(order);
      for (i = 0; i < count; i++) begin
         if (restart_pct < 0) walk_requests.push_back(pattern[i]);
         else walk_requests.push_back($urandom_range(99) < restart_pct);
      end
      while (walk_requests.size() != 0 || segments_due.size() != 0) @(posedge clock);
   endtask

   initial begin
      int k;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_gap_pct = 35;
      recv_stall_pct = 77;
      // Directed: reset order, then order zero acting as one with wraps and restarts,
      // an order above the maximum, and the smallest order.
      run_section(1'b0, ORDER_RESET, 5, -1, 32'b01000);
      run_section(1'b1, 4'd0, 8, -1, 32'b00100000);
      run_section(1'b1, 4'd15, 4, -1, 32'b0100);
      run_section(1'b1, ORDER_MIN, 6, -1, 32'b000100);

      for (k = 0; k < 12; k++) begin
         if (k == 4) begin
            send_gap_pct = 77;
            recv_stall_pct = 35;
         end else if (k == 8) begin
            send_gap_pct = 0;
            recv_stall_pct = 0;
         end
         run_section(1'b1, ORDER_W'(plan_order[k]), plan_len[k], plan_restart[k], '0);
      end

      repeat (12) @(posedge clock);
      if (mismatches == 0 && segments_due.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== hilbert_curve_step_generator.f =====
rtl/hcsg_pkg.sv
rtl/hcsg_walk.sv
rtl/hcsg_level_stage.sv
rtl/hcsg_out.sv
rtl/hilbert_curve_step_generator.sv
dv/tb_hilbert_curve_step_generator.sv
